/* sv/ips_pkg.sv */
package ips_pkg;

   localparam int CountBits = 10;
   localparam int RegBits = 10;
   localparam int NumTimed = 7;
   localparam int NumRegs = 8;
   localparam int IndexBits = 4;
   localparam int LenBits = (CountBits > RegBits) ? CountBits : RegBits;
   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

   localparam logic [IndexBits-1:0] REG_GAP = 4'd0;
   localparam logic [IndexBits-1:0] REG_DISCHARGE = 4'd1;
   localparam logic [IndexBits-1:0] REG_SETTLE = 4'd2;
   localparam logic [IndexBits-1:0] REG_SOFT_ON = 4'd3;
   localparam logic [IndexBits-1:0] REG_SOFT_OFF = 4'd4;
   localparam logic [IndexBits-1:0] REG_MAIN_ON = 4'd5;
   localparam logic [IndexBits-1:0] REG_WATCH = 4'd6;
   localparam logic [IndexBits-1:0] REG_CONTINUOUS = 4'd7;

   localparam logic [RegBits-1:0] GAP_RESET = 10'd10;
   localparam logic [RegBits-1:0] DISCHARGE_RESET = 10'd20;
   localparam logic [RegBits-1:0] SETTLE_RESET = 10'd750;
   localparam logic [RegBits-1:0] SOFT_ON_RESET = 10'd5;
   localparam logic [RegBits-1:0] SOFT_OFF_RESET = 10'd5;
   localparam logic [RegBits-1:0] MAIN_ON_RESET = 10'd30;
   localparam logic [RegBits-1:0] WATCH_RESET = 10'd100;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_GAP      = 4'd1,
      PH_DIS      = 4'd2,
      PH_SETTLE   = 4'd3,
      PH_SOFT_ON  = 4'd4,
      PH_SOFT_OFF = 4'd5,
      PH_MAIN     = 4'd6,
      PH_WATCH    = 4'd7,
      PH_REARM    = 4'd8
   } phase_type;

   typedef struct packed {
      logic enable_n;
      logic overcurrent_n;
   } req_type;

   typedef struct packed {
      logic      charge_drive;
      logic      discharge_drive;
      logic      led_on;
      phase_type phase;
   } rsp_type;

   typedef struct packed {
      logic [NumTimed-1:0][RegBits-1:0] dur;
      logic                             continuous;
   } cfg_type;

endpackage

/* sv/ips_csr.sv */
module ips_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [ips_pkg::IndexBits-1:0]      csr_index,
   input  logic [ips_pkg::RegBits-1:0]        csr_wdata,
   output ips_pkg::cfg_type                   cfg
);

   ips_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            ips_pkg::REG_GAP:        cfg_in.dur[0] = csr_wdata;
            ips_pkg::REG_DISCHARGE:  cfg_in.dur[1] = csr_wdata;
            ips_pkg::REG_SETTLE:     cfg_in.dur[2] = csr_wdata;
            ips_pkg::REG_SOFT_ON:    cfg_in.dur[3] = csr_wdata;
            ips_pkg::REG_SOFT_OFF:   cfg_in.dur[4] = csr_wdata;
            ips_pkg::REG_MAIN_ON:    cfg_in.dur[5] = csr_wdata;
            ips_pkg::REG_WATCH:      cfg_in.dur[6] = csr_wdata;
            ips_pkg::REG_CONTINUOUS: cfg_in.continuous = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dur[0] <= ips_pkg::GAP_RESET;
         cfg_ff.dur[1] <= ips_pkg::DISCHARGE_RESET;
         cfg_ff.dur[2] <= ips_pkg::SETTLE_RESET;
         cfg_ff.dur[3] <= ips_pkg::SOFT_ON_RESET;
         cfg_ff.dur[4] <= ips_pkg::SOFT_OFF_RESET;
         cfg_ff.dur[5] <= ips_pkg::MAIN_ON_RESET;
         cfg_ff.dur[6] <= ips_pkg::WATCH_RESET;
         cfg_ff.continuous <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/ips_core.sv */
module ips_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ips_pkg::req_type  req,
   input  ips_pkg::cfg_type  cfg,
   output ips_pkg::rsp_type  rsp
);

   ips_pkg::phase_type phase_ff, phase_in;
   logic [ips_pkg::CountBits-1:0] count_ff, count_in;

   ips_pkg::phase_type ph;
   logic [ips_pkg::CountBits-1:0] cnt, cnt_inc;
   logic [2:0] sel;
   logic [ips_pkg::LenBits-1:0] len_w, cnt_w;
   logic en_low, oc_low, cont, done;

   always_comb begin
      en_low = ~req.enable_n;
      oc_low = ~req.overcurrent_n;
      cont = cfg.continuous;
      ph = phase_ff;
      cnt = count_ff;
      if (phase_ff == ips_pkg::PH_IDLE && (en_low || cont)) begin
         ph = ips_pkg::PH_GAP;
         cnt = '0;
      end
      cnt_inc = cnt + 1'b1;
      sel = 3'(4'(ph) - 4'd1);
      len_w = ips_pkg::LenBits'(cfg.dur[sel]);
      cnt_w = ips_pkg::LenBits'(cnt_inc);
      // count at the top of its range ends the phase (saturated length)
      done = (cnt_w >= len_w) || (cnt_inc == ips_pkg::CountMax) || (cnt_inc == '0);

      phase_in = phase_ff;
      count_in = count_ff;
      rsp.charge_drive = 1'b0;
      rsp.discharge_drive = 1'b0;
      rsp.led_on = 1'b0;
      rsp.phase = ph;

      case (ph)
         ips_pkg::PH_IDLE: begin
            phase_in = ips_pkg::PH_IDLE;
         end
         ips_pkg::PH_REARM: begin
            if (!en_low || cont) begin
               phase_in = ips_pkg::PH_IDLE;
               count_in = '0;
            end else begin
               phase_in = ips_pkg::PH_REARM;
            end
         end
         ips_pkg::PH_GAP, ips_pkg::PH_DIS, ips_pkg::PH_SETTLE, ips_pkg::PH_SOFT_ON,
         ips_pkg::PH_SOFT_OFF, ips_pkg::PH_MAIN, ips_pkg::PH_WATCH: begin
            if (ph == ips_pkg::PH_WATCH && oc_low) begin
               // overcurrent abort: all drives off
               rsp.phase = ips_pkg::PH_REARM;
               phase_in = cont ? ips_pkg::PH_GAP : ips_pkg::PH_REARM;
               count_in = '0;
            end else begin
               rsp.discharge_drive = (ph == ips_pkg::PH_DIS);
               rsp.charge_drive = (ph == ips_pkg::PH_SOFT_ON) || (ph == ips_pkg::PH_MAIN) ||
                                  (ph == ips_pkg::PH_WATCH);
               rsp.led_on = (ph != ips_pkg::PH_GAP);
               if (done) begin
                  count_in = '0;
                  if (ph == ips_pkg::PH_WATCH) begin
                     phase_in = cont ? ips_pkg::PH_GAP : ips_pkg::PH_REARM;
                  end else begin
                     phase_in = ips_pkg::phase_type'(4'(ph) + 4'd1);
                  end
               end else begin
                  count_in = cnt_inc;
                  phase_in = ph;
               end
            end
         end
         default: begin
            rsp.phase = ips_pkg::PH_IDLE;
            phase_in = ips_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ips_pkg::PH_IDLE;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

/* sv/ignition_pulse_sequencer.sv */
// Ignition pulse sequencer. Each request is one timing tick carrying the enable and
// overcurrent pin levels; each tick yields exactly one response with the charge,
// discharge and LED drives and the phase of that tick. A request is taken every cycle
// and its response appears in the output register in the next cycle; the only
// limit is that output register, so a request is taken whenever the response
// register is empty or being drained. Phase durations and continuous mode sit in
// csr registers 0..7 and should be written while no ticks are in flight.
module ignition_pulse_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ips_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ips_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic [ips_pkg::IndexBits-1:0] csr_index,
   input  logic [ips_pkg::RegBits-1:0]   csr_wdata
);

   ips_pkg::cfg_type cfg;
   ips_pkg::rsp_type step_rsp;
   ips_pkg::rsp_type rsp_data_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   ips_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ips_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp    (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_no_shoot_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.charge_drive && rsp_data_ff.discharge_drive))
      else $error("charge and discharge on together");

   a_quiet_phases: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.phase == ips_pkg::PH_IDLE ||
                       rsp_data_ff.phase == ips_pkg::PH_GAP ||
                       rsp_data_ff.phase == ips_pkg::PH_REARM)
      |-> !(rsp_data_ff.charge_drive || rsp_data_ff.discharge_drive || rsp_data_ff.led_on))
      else $error("drive on in a quiet phase");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request left no response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

endmodule
